// ===== design/tgfw_pkg.sv =====
// shared types, constants and font table for the text glyph framebuffer writer
`timescale 1ns / 1ps
package tgfw_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 84;
  localparam int unsigned SCREEN_HEIGHT_DEF = 48;
  localparam logic [7:0]  NEWLINE_CODE      = 8'h0A;
  localparam logic [7:0]  FIRST_GLYPH       = 8'd32;
  localparam logic [7:0]  LAST_GLYPH        = 8'h7F;
  localparam int unsigned GLYPH_COLS        = 5;
  localparam int unsigned GLYPH_ROWS        = 7;

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SETCUR = 2'd2,
    OP_READ   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_SETCUR,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [6:0]  glyph;
    logic [7:0]  new_x;
    logic [7:0]  new_y;
    logic [8:0]  byte_address;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_READ,
    ST_DONE
  } back_state_e;

  // column 0 in the top byte
  localparam logic [39:0] FONT_ROM [96] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
  };

  function automatic logic [6:0] font_col(input logic [6:0] glyph, input logic [2:0] idx);
    logic [39:0] entry;
    logic [6:0]  bits;
    entry = FONT_ROM[glyph];
    case (idx)
      3'd0:    bits = entry[38:32];
      3'd1:    bits = entry[30:24];
      3'd2:    bits = entry[22:16];
      3'd3:    bits = entry[14:8];
      3'd4:    bits = entry[6:0];
      default: bits = 7'd0;
    endcase
    return bits;
  endfunction

  // small quotient v / s for s in 1..4 and v below 32
  function automatic logic [4:0] div_scale(input logic [4:0] v, input logic [2:0] s);
    logic [8:0]  prod;
    logic [4:0]  q;
    prod = 9'(v) * 9'd11;
    case (s)
      3'd2:    q = v >> 1;
      3'd3:    q = 5'(prod >> 5);
      3'd4:    q = v >> 2;
      default: q = v;
    endcase
    return q;
  endfunction

endpackage

// ===== design/tgfw_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module tgfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 504,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tgfw_front.sv =====
// front end: decodes incoming beats and queues them for the executor
`timescale 1ns / 1ps
module tgfw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    char_code_i,
  input  logic [7:0]    new_x_i,
  input  logic [7:0]    new_y_i,
  input  logic [8:0]    byte_address_i,
  input  logic          init_busy_i,
  output logic          cmd_valid_o,
  output tgfw_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import tgfw_pkg::*;

  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_new;
  logic       push;

  always_comb begin
    cmd_new              = '0;
    cmd_new.new_x        = new_x_i;
    cmd_new.new_y        = new_y_i;
    cmd_new.byte_address = byte_address_i;
    case (opcode_e'(opcode_i))
      OP_CHAR: begin
        if (char_code_i == NEWLINE_CODE) begin
          cmd_new.kind = CMD_NEWLINE;
        end else begin
          cmd_new.kind = CMD_CHAR;
          // unknown codes fall back to the space glyph
          if (char_code_i >= FIRST_GLYPH && char_code_i <= LAST_GLYPH) begin
            cmd_new.glyph = 7'(char_code_i - FIRST_GLYPH);
          end
        end
      end
      OP_CLEAR:  cmd_new.kind = CMD_CLEAR;
      OP_SETCUR: cmd_new.kind = CMD_SETCUR;
      OP_READ:   cmd_new.kind = CMD_READ;
      default:   cmd_new.kind = CMD_READ;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2) && !init_busy_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== design/tgfw_back.sv =====
// executor: cursor logic, glyph drawing, clearing and read-back on the frame store
`timescale 1ns / 1ps
module tgfw_back #(
  parameter int unsigned SCREEN_WIDTH  = tgfw_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tgfw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_wdata_i,
  input  logic           cmd_valid_i,
  input  tgfw_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           init_busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     read_byte_o,
  output logic [7:0]     cursor_col_o,
  output logic [7:0]     cursor_row_o,
  output logic           screen_cleared_o
);
  import tgfw_pkg::*;

  localparam int unsigned BANKS  = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned STORE  = SCREEN_WIDTH * BANKS;
  localparam int unsigned ADDR_W = $clog2(STORE);
  localparam int unsigned LIN_W  = 14;

  back_state_e state_q, state_d;

  logic [2:0]        scale_q;
  logic [7:0]        col_q, row_q;
  logic              cleared_q, draw_after_q;
  logic [7:0]        rd_q;
  logic [6:0]        glyph_q;
  logic [4:0]        xi_q;
  logic [5:0]        bank_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              ov_q;
  logic [7:0]        out_rd_q, out_col_q, out_row_q;
  logic              out_clr_q;

  logic [2:0]        eff;
  logic [7:0]        step_row;
  logic [7:0]        step_col;
  logic [4:0]        last_xi;
  logic [5:0]        b0, b1;
  logic              wrap, full;
  logic [7:0]        c_w, r_w;
  logic [8:0]        px;
  logic              cell_ok;
  logic [LIN_W-1:0]  lin;
  logic [LIN_W-1:0]  rd_addr_ext;
  logic              rd_in_range;
  logic              clr_last;
  logic              advance, last_cell;
  logic              slot_free;
  logic [6:0]        colbits;
  logic [7:0]        colbits_x;
  logic [7:0]        mask, bits, merged;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // out of range scale settings saturate into 1..4
  assign eff = (scale_q == 3'd0) ? 3'd1 : ((scale_q > 3'd4) ? 3'd4 : scale_q);
  assign step_row = 8'(8'(eff) * 8'(GLYPH_ROWS) + 8'd1);
  assign step_col = 8'(8'(eff) * 8'(GLYPH_COLS) + 8'd1);
  assign last_xi  = 5'(5'(eff) * 5'(GLYPH_COLS) - 5'd1);
  assign b0       = 6'(row_q >> 3);
  assign b1       = 6'((9'(row_q) + 9'(eff) * 9'(GLYPH_ROWS) - 9'd1) >> 3);

  assign wrap = 9'(col_q) >= 9'(SCREEN_WIDTH);
  assign c_w  = wrap ? 8'd0 : col_q;
  assign r_w  = wrap ? 8'(row_q + step_row) : row_q;
  assign full = 9'(r_w) >= 9'(SCREEN_HEIGHT);

  assign px      = 9'(col_q) + 9'(xi_q);
  assign cell_ok = (px < 9'(SCREEN_WIDTH)) && (7'(bank_q) < 7'(BANKS));
  assign lin     = LIN_W'(bank_q) * LIN_W'(SCREEN_WIDTH) + LIN_W'(px);

  assign rd_addr_ext = LIN_W'(cmd_i.byte_address);
  assign rd_in_range = rd_addr_ext < LIN_W'(STORE);
  assign clr_last    = clr_addr_q == ADDR_W'(STORE - 1);

  assign last_cell = (bank_q >= b1) && (xi_q == last_xi);
  assign advance   = ((state_q == ST_DRAW_RD) && !cell_ok) || (state_q == ST_DRAW_WR);
  assign slot_free = !ov_q || out_ready_i;

  // merge one glyph column into one stored byte
  always_comb begin
    logic [8:0] py;
    logic [8:0] rel;
    logic [4:0] q;
    colbits   = font_col(glyph_q, 3'(div_scale(xi_q, eff)));
    colbits_x = {1'b0, colbits};
    mask      = '0;
    bits      = '0;
    for (int n = 0; n < 8; n++) begin
      py  = {bank_q, 3'(n)};
      rel = py - 9'(row_q);
      q   = div_scale(rel[4:0], eff);
      if (py >= 9'(row_q) && rel < 9'(eff) * 9'(GLYPH_ROWS) &&
          py < 9'(SCREEN_HEIGHT)) begin
        mask[n] = 1'b1;
        bits[n] = colbits_x[q[2:0]];
      end
    end
    merged = (ram_rdata & ~mask) | (bits & mask);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_CHAR:  state_d = full ? ST_CLEAR : ST_DRAW_RD;
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_READ:  state_d = rd_in_range ? ST_READ : ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_d = draw_after_q ? ST_DRAW_RD : ST_DONE;
      end
      ST_DRAW_RD: begin
        if (cell_ok) state_d = ST_DRAW_WR;
        else if (last_cell) state_d = ST_DONE;
      end
      ST_DRAW_WR: begin
        state_d = last_cell ? ST_DONE : ST_DRAW_RD;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    cmd_pop_o   = 1'b0;
    init_busy_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_q;
    ram_wdata   = 8'd0;
    ram_raddr   = ADDR_W'(lin);
    case (state_q)
      ST_INIT: begin
        init_busy_o = 1'b1;
        ram_we      = 1'b1;
      end
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        ram_raddr = rd_addr_ext[ADDR_W-1:0];
      end
      ST_CLEAR: ram_we = 1'b1;
      ST_DRAW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(lin);
        ram_wdata = merged;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      scale_q      <= 3'd1;
      col_q        <= 8'd0;
      row_q        <= 8'd0;
      cleared_q    <= 1'b0;
      draw_after_q <= 1'b0;
      clr_addr_q   <= '0;
      ov_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      // a new beat loads the slot, otherwise a taken beat empties it
      if ((state_q == ST_DONE) && slot_free) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        ST_INIT, ST_CLEAR: clr_addr_q <= clr_addr_q + ADDR_W'(1);
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cleared_q    <= 1'b0;
            draw_after_q <= 1'b0;
            clr_addr_q   <= '0;
            case (cmd_i.kind)
              CMD_CHAR: begin
                col_q        <= full ? 8'd0 : c_w;
                row_q        <= full ? 8'd0 : r_w;
                cleared_q    <= full;
                draw_after_q <= 1'b1;
              end
              CMD_NEWLINE: begin
                col_q <= 8'd0;
                row_q <= 8'(row_q + step_row);
              end
              CMD_CLEAR: begin
                col_q     <= 8'd0;
                row_q     <= 8'd0;
                cleared_q <= 1'b1;
              end
              CMD_SETCUR: begin
                col_q <= cmd_i.new_x;
                row_q <= cmd_i.new_y;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      if (advance && last_cell) col_q <= 8'(col_q + step_col);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          glyph_q <= cmd_i.glyph;
          rd_q    <= 8'd0;
          xi_q    <= 5'd0;
          bank_q  <= full ? 6'd0 : 6'(r_w >> 3);
        end
      end
      ST_READ: rd_q <= ram_rdata;
      ST_DONE: begin
        if (slot_free) begin
          out_rd_q  <= rd_q;
          out_col_q <= col_q;
          out_row_q <= row_q;
          out_clr_q <= cleared_q;
        end
      end
      default: ;
    endcase
    if (advance && !last_cell) begin
      if (bank_q < b1) begin
        bank_q <= bank_q + 6'd1;
      end else begin
        bank_q <= b0;
        xi_q   <= xi_q + 5'd1;
      end
    end
  end

  tgfw_ram #(
    .WIDTH(8),
    .DEPTH(STORE)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o      = ov_q;
  assign read_byte_o      = out_rd_q;
  assign cursor_col_o     = out_col_q;
  assign cursor_row_o     = out_row_q;
  assign screen_cleared_o = out_clr_q;

endmodule

// ===== design/text_glyph_framebuffer_writer.sv =====
// top level of the text glyph framebuffer writer
`timescale 1ns / 1ps
// Draws 5x7 text, scaled 1..4, into a page-organised monochrome frame store
// (SCREEN_WIDTH bytes per 8-row bank) and returns one result beat per command
// with the cursor afterwards. After reset the store is swept to zero, one byte
// a cycle (SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes, 504 at default sizes);
// no command is taken meanwhile. A clear sweeps the whole store the same way.
// A character does a read-modify-write on the single frame ram port pair for
// every column and bank it covers, after a full sweep when the page is full.
// Two commands are queued ahead of the executor and one result is held for
// the output.
module text_glyph_framebuffer_writer #(
  parameter int unsigned SCREEN_WIDTH  = tgfw_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tgfw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] new_x_i,
  input  logic [7:0] new_y_i,
  input  logic [8:0] byte_address_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_byte_o,
  output logic [7:0] cursor_col_o,
  output logic [7:0] cursor_row_o,
  output logic       screen_cleared_o
);
  import tgfw_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop, init_busy;

  tgfw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .char_code_i   (char_code_i),
    .new_x_i       (new_x_i),
    .new_y_i       (new_y_i),
    .byte_address_i(byte_address_i),
    .init_busy_i   (init_busy),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tgfw_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .init_busy_o     (init_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_byte_o     (read_byte_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .screen_cleared_o(screen_cleared_o)
  );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the text glyph framebuffer writer
`timescale 1ns / 1ps
module testbench;
  import tgfw_pkg::*;

  localparam int unsigned WIDTH       = SCREEN_WIDTH_DEF;
  localparam int unsigned HEIGHT      = SCREEN_HEIGHT_DEF;
  localparam int unsigned STORE_BYTES = WIDTH * ((HEIGHT + 7) / 8);

  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       screen_cleared;
  } text_result_t;

  class text_scoreboard;
    logic [7:0]   frame_bytes [STORE_BYTES];
    logic [7:0]   col, row;
    logic [2:0]   scale_reg;
    text_result_t pending_results [$];
    int           mismatches;
    int           checked;

    function void clear_page();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'd0;
      col = 8'd0;
      row = 8'd0;
    endfunction

    function new();
      clear_page();
      scale_reg  = 3'd1;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned eff_scale();
      if (scale_reg == 3'd0) return 1;
      if (scale_reg > 3'd4) return 4;
      return scale_reg;
    endfunction

    function void plot(int unsigned px, int unsigned py, bit on);
      int unsigned idx;
      if (px >= WIDTH || py >= HEIGHT) return;
      idx = (py / 8) * WIDTH + px;
      if (on) frame_bytes[idx][py % 8] = 1'b1;
      else frame_bytes[idx][py % 8] = 1'b0;
    endfunction

    // returns 1 when the page was full and got wiped
    function bit draw_glyph(logic [7:0] code);
      int unsigned s, g;
      logic [39:0] entry;
      logic [7:0]  bits;
      bit          wiped;
      s = eff_scale();
      wiped = 1'b0;
      if (code == NEWLINE_CODE) begin
        col = 8'd0;
        row = row + 8'(7 * s + 1);
        return 1'b0;
      end
      if (col >= WIDTH) begin
        col = 8'd0;
        row = row + 8'(7 * s + 1);
      end
      if (row >= HEIGHT) begin
        clear_page();
        wiped = 1'b1;
      end
      g = (code >= FIRST_GLYPH && code <= LAST_GLYPH) ? code - FIRST_GLYPH : 0;
      entry = FONT_ROM[g];
      for (int unsigned x = 0; x < 5 * s; x++) begin
        bits = entry[39 - 8 * (x / s) -: 8];
        for (int unsigned y = 0; y < 7 * s; y++)
          plot(int'(col) + x, int'(row) + y, bits[y / s]);
      end
      col = col + 8'(5 * s + 1);
      return wiped;
    endfunction

    function void note_command(opcode_e op, logic [7:0] code, logic [7:0] nx,
                               logic [7:0] ny, logic [8:0] addr);
      text_result_t r;
      r = '0;
      case (op)
        OP_CHAR: r.screen_cleared = draw_glyph(code);
        OP_CLEAR: begin
          clear_page();
          r.screen_cleared = 1'b1;
        end
        OP_SETCUR: begin
          col = nx;
          row = ny;
        end
        default: if (addr < STORE_BYTES) r.read_byte = frame_bytes[addr];
      endcase
      r.cursor_col = col;
      r.cursor_row = row;
      pending_results.push_back(r);
    endfunction

    function void check_result(text_result_t got);
      text_result_t exp_r;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.read_byte != exp_r.read_byte || got.cursor_col != exp_r.cursor_col ||
          got.cursor_row != exp_r.cursor_row ||
          got.screen_cleared != exp_r.screen_cleared) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: byte %h/%h col %0d/%0d row %0d/%0d cleared %b/%b (exp/got)",
                   checked, exp_r.read_byte, got.read_byte, exp_r.cursor_col,
                   got.cursor_col, exp_r.cursor_row, got.cursor_row,
                   exp_r.screen_cleared, got.screen_cleared);
      end
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  logic       in_valid_i, in_ready_o;
  logic [1:0] opcode_i;
  logic [7:0] char_code_i, new_x_i, new_y_i;
  logic [8:0] byte_address_i;
  logic       out_valid_o, out_ready_i;
  logic [7:0] read_byte_o, cursor_col_o, cursor_row_o;
  logic       screen_cleared_o;

  text_scoreboard sb;
  int             send_idle_pct, recv_idle_pct;
  int             cmd_count;

  text_glyph_framebuffer_writer uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .opcode_i, .char_code_i, .new_x_i, .new_y_i, .byte_address_i,
    .out_valid_o, .out_ready_i, .read_byte_o, .cursor_col_o, .cursor_row_o,
    .screen_cleared_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ready only moves on the rising edge, so the falling edge sees the beat
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({read_byte_o, cursor_col_o, cursor_row_o, screen_cleared_o});
  end

  task automatic send_cmd(opcode_e op, logic [7:0] code, logic [7:0] nx,
                          logic [7:0] ny, logic [8:0] addr);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    char_code_i    <= code;
    new_x_i        <= nx;
    new_y_i        <= ny;
    byte_address_i <= addr;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_command(op, code, nx, ny, addr);
    cmd_count++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [2:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.scale_reg = v;
  endtask

  task automatic send_random_cmd();
    int unsigned pick, sel;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 70) begin
      if (sel < 80) send_cmd(OP_CHAR, 8'($urandom_range(32, 127)), 8'($urandom), 8'($urandom),
                             9'($urandom));
      else if (sel < 88) send_cmd(OP_CHAR, NEWLINE_CODE, 8'($urandom), 8'($urandom),
                                  9'($urandom));
      else send_cmd(OP_CHAR, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
    end else if (pick < 80) begin
      if (sel < 60) send_cmd(OP_SETCUR, 8'($urandom), 8'($urandom_range(0, 90)),
                             8'($urandom_range(0, 50)), 9'($urandom));
      else send_cmd(OP_SETCUR, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
    end else if (pick < 97) begin
      send_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom_range(0, 511)));
    end else begin
      send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
    end
  endtask

  logic [2:0] scale_plan [15] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6,
                                  3'd1, 3'd4, 3'd2, 3'd3, 3'd4, 3'd1, 3'd3};

  initial begin
    sb             = new();
    cmd_count      = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 3'd1;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    opcode_i       = OP_CHAR;
    char_code_i    = 8'd0;
    new_x_i        = 8'd0;
    new_y_i        = 8'd0;
    byte_address_i = 9'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at scale 1
    write_scale(3'd1);
    send_cmd(OP_READ,   8'h00, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_CHAR,   8'h41, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_CHAR,   8'h00, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_CHAR,   8'hFF, 8'hFF, 8'hFF, 9'h1FF);
    send_cmd(OP_CHAR,   8'h7F, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_CHAR,   8'h20, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_CHAR,   NEWLINE_CODE, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_READ,   8'h00, 8'h00, 8'h00, 9'd1);
    send_cmd(OP_SETCUR, 8'h00, 8'd80, 8'd0, 9'd0);
    send_cmd(OP_CHAR,   8'h57, 8'h00, 8'h00, 9'd0);   // clipped at the right edge
    send_cmd(OP_SETCUR, 8'h00, 8'd79, 8'd44, 9'd0);
    send_cmd(OP_CHAR,   8'h23, 8'h00, 8'h00, 9'd0);   // clipped at the bottom
    send_cmd(OP_READ,   8'h00, 8'h00, 8'h00, 9'd503);
    send_cmd(OP_READ,   8'h00, 8'h00, 8'h00, 9'd504);
    send_cmd(OP_READ,   8'h00, 8'h00, 8'h00, 9'd511);
    send_cmd(OP_SETCUR, 8'h00, 8'd10, 8'd48, 9'd0);
    send_cmd(OP_CHAR,   8'h42, 8'h00, 8'h00, 9'd0);   // page full
    send_cmd(OP_SETCUR, 8'h00, 8'd255, 8'd255, 9'd0);
    send_cmd(OP_CHAR,   8'h43, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_SETCUR, 8'h00, 8'd0, 8'd250, 9'd0);
    send_cmd(OP_CHAR,   NEWLINE_CODE, 8'h00, 8'h00, 9'd0);   // row wraps
    send_cmd(OP_CLEAR,  8'h00, 8'h00, 8'h00, 9'd0);
    send_cmd(OP_READ,   8'h00, 8'h00, 8'h00, 9'd84);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 8 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        write_scale(scale_plan[phase * 5 + seg]);
        for (int n = 0; n < 117; n++) begin
          send_random_cmd();
          if (phase == 0 && seg == 2 && n == 60) drain_results();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("sent %0d commands over scales 0..7 and three handshake pressure mixes",
             cmd_count);
    $display("checked %0d result beats, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
